[hw/rtl/twcbr_pkg.sv]
// Shared types and field constants for the two-way byte-read cache.
package twcbr_pkg;

  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFS_W   = 2;
  localparam int unsigned SETF_W   = 5;
  localparam int unsigned TAG_W    = 13;
  localparam int unsigned SETF_LO  = OFFS_W;
  localparam int unsigned TAG_LO   = OFFS_W + SETF_W;
  localparam int unsigned SETF_CNT = 1 << SETF_W;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TAG_W-1:0]  tag_t;

  typedef struct packed {
    addr_t byte_addr;
    word_t memory_word;
  } req_t;

  typedef struct packed {
    byte_t data_byte;
    logic  was_hit;
  } rsp_t;

endpackage

[hw/rtl/two_way_cache_byte_read.sv]
// Two-way set-associative read cache, one 32-bit word per line, byte result.
//
// Input channel in_*: each item carries a 20-bit byte address and the word
// memory holds at that address (used only on a miss). Address bits 1:0 pick
// the byte, 6:2 the set (reduced modulo SET_COUNT), 19:7 form the tag.
// Result channel out_*: the selected byte on out_tdata, hit flag on out_tuser.
// On a hit the matching way supplies the byte (way 1 if both match). On a
// miss the word fills the first invalid way, else the older way of the set.
//
// Throughput: one item per cycle while the receiver does not stall. An item
// is captured in the input register, then the tag compare, fill and byte
// select run combinationally into the result register, so back-to-back
// items to the same set see the updated lines. When the receiver stalls, the
// result register holds its item and the input register can still take one
// more; in_tready drops only when both are full.
// Reset (rst_n low, synchronous) invalidates every line and makes way 0 the
// older way of every set; the cache is usable in the first cycle after it.
module two_way_cache_byte_read #(
  parameter int unsigned SET_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // byte_addr [19:0], memory_word [51:20], zero pad [55:52]
  input  logic [twcbr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // data_byte [7:0]
  output logic [twcbr_pkg::OUT_DATA_W-1:0] out_tdata,
  // was_hit [0]
  output logic                          out_tuser
);
  import twcbr_pkg::*;

  localparam int unsigned DEPTH = (SET_COUNT < SETF_CNT) ? SET_COUNT : SETF_CNT;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [IDX_W-1:0] set_map [SETF_CNT];

  for (genvar gi = 0; gi < SETF_CNT; gi++) begin : g_set_map
    assign set_map[gi] = IDX_W'(gi % SET_COUNT);
  end

  logic             in_valid_r;
  req_t             req_r;
  logic             out_valid_r;
  rsp_t             rsp_r;

  logic [DEPTH-1:0] v0_r, v1_r, victim_r;
  logic [DEPTH-1:0] v0_nxt, v1_nxt, victim_nxt;
  tag_t             tag0_r  [DEPTH];
  tag_t             tag1_r  [DEPTH];
  word_t            word0_r [DEPTH];
  word_t            word1_r [DEPTH];

  logic             advance;
  logic             lookup;
  logic [IDX_W-1:0] idx;
  tag_t             tag;
  logic [OFFS_W-1:0] offs;
  logic             hit0, hit1, hit;
  logic             fill0, fill1;
  word_t            sel_word;
  rsp_t             rsp_nxt;

  assign advance   = !out_valid_r || out_tready;
  assign lookup    = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign offs = req_r.byte_addr[OFFS_W-1:0];
  assign idx  = set_map[req_r.byte_addr[TAG_LO-1:SETF_LO]];
  assign tag  = req_r.byte_addr[ADDR_W-1:TAG_LO];

  always_comb begin
    hit0     = v0_r[idx] && (tag0_r[idx] == tag);
    hit1     = v1_r[idx] && (tag1_r[idx] == tag);
    hit      = hit0 || hit1;
    fill0    = 1'b0;
    fill1    = 1'b0;
    sel_word = req_r.memory_word;
    if (hit1) begin
      sel_word = word1_r[idx];
    end else if (hit0) begin
      sel_word = word0_r[idx];
    end
    if (lookup && !hit) begin
      priority if (!v0_r[idx]) begin
        fill0 = 1'b1;
      end else if (!v1_r[idx]) begin
        fill1 = 1'b1;
      end else if (victim_r[idx]) begin
        fill1 = 1'b1;
      end else begin
        fill0 = 1'b1;
      end
    end
    v0_nxt     = v0_r;
    v1_nxt     = v1_r;
    victim_nxt = victim_r;
    if (fill0) begin
      v0_nxt[idx]     = 1'b1;
      victim_nxt[idx] = 1'b1;
    end
    if (fill1) begin
      v1_nxt[idx]     = 1'b1;
      victim_nxt[idx] = 1'b0;
    end
    rsp_nxt.data_byte = sel_word[{offs, 3'b000} +: BYTE_W];
    rsp_nxt.was_hit   = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      v0_r        <= '0;
      v1_r        <= '0;
      victim_r    <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      v0_r     <= v0_nxt;
      v1_r     <= v1_nxt;
      victim_r <= victim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.byte_addr   <= in_tdata[ADDR_W-1:0];
      req_r.memory_word <= in_tdata[ADDR_W+WORD_W-1:ADDR_W];
    end
    if (lookup) begin
      rsp_r <= rsp_nxt;
    end
    if (fill0) begin
      tag0_r[idx]  <= tag;
      word0_r[idx] <= req_r.memory_word;
    end
    if (fill1) begin
      tag1_r[idx]  <= tag;
      word1_r[idx] <= req_r.memory_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rsp_r.data_byte;
  assign out_tuser  = rsp_r.was_hit;

  a_lookup_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    lookup |=> out_valid_r)
    else $error("lookup did not produce a result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  a_single_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !(fill0 && fill1) && !(hit && (fill0 || fill1)))
    else $error("conflicting fill");

  a_valid_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v0_r) >= $past($countones(v0_r)))
          && ($countones(v1_r) >= $past($countones(v1_r))))
    else $error("valid bit dropped");

endmodule
